// File: hw/rtl/epoch_seconds_to_calendar_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the epoch seconds to calendar block
// Shared helpers so every checker reports in one form.
// ---------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH

// Concurrent check on clk_i, off while rst_ni is low
`define ES2CAL_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same check with a generic message
`define ES2CAL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("es2cal: check failed");

`endif

// File: hw/rtl/es2cal_pkg.sv
// ---------------------------------------------------------------------------
// es2cal_pkg
// Constants and helpers for the epoch seconds to calendar converter.
// ---------------------------------------------------------------------------
package es2cal_pkg;

  // seconds per day = 2^7 * 675; reciprocal of 675 scaled by 2^34 (floor)
  localparam logic [24:0] DayRecip      = 25'd25451658;
  localparam logic [16:0] SecPerDay     = 17'd86400;

  // day count is rebased to 1968-01-01 so 4-year cycles start on a leap year
  localparam logic [14:0] EpochDayOfs   = 15'd731;
  localparam logic [10:0] BaseYear      = 11'd1968;
  localparam logic [10:0] QuadDays      = 11'd1461;
  // reciprocal of 1461 scaled by 2^25 (floor)
  localparam logic [14:0] QuadRecip     = 15'd22966;

  // reciprocal of 15 scaled by 2^20 (floor); x/60 = (x>>2)/15
  localparam logic [16:0] Recip15       = 17'd69905;
  localparam logic [5:0]  Sixty         = 6'd60;

  // 1970-01-01 was a Thursday, Monday = 0
  localparam logic [2:0]  EpochWeekday  = 3'd3;
  localparam logic [2:0]  DaysPerWeek   = 3'd7;

  // day-of-year thresholds inside a 4-year cycle
  localparam logic [10:0] Year1Start    = 11'd366;
  localparam logic [10:0] Year2Start    = 11'd731;
  localparam logic [10:0] Year3Start    = 11'd1096;

  // first day of month (0-based index) within the year
  function automatic logic [8:0] month_start(input logic [3:0] mi, input logic leap);
    logic [8:0] base;
    case (mi)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      default: base = 9'd334;
    endcase
    return base + ((leap && (mi >= 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

// File: hw/rtl/es2cal_if.sv
// ---------------------------------------------------------------------------
// es2cal_if
// Valid/ready channels: seconds word in, calendar word out.
// ---------------------------------------------------------------------------
interface es2cal_in_if;
  logic        valid;
  logic        ready;
  logic [30:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface es2cal_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [10:0] year_number;
  logic [2:0]  weekday;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic [5:0]  second_of_minute;

  modport source (output valid, output day_of_month, output month_number,
                  output year_number, output weekday, output hour_of_day,
                  output minute_of_hour, output second_of_minute, input ready);
  modport sink   (input valid, input day_of_month, input month_number,
                  input year_number, input weekday, input hour_of_day,
                  input minute_of_hour, input second_of_minute, output ready);
endinterface

// File: hw/rtl/epoch_seconds_to_calendar_top.sv
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts seconds since 1970-01-01 00:00:00 UTC into date, weekday and time.
// ---------------------------------------------------------------------------
// A nine-stage pipeline. The accepting edge loads stage one, and the word
// then moves through stages two to nine in order; stage nine is the output
// register. One word can enter every cycle while the output is not stalled,
// so throughput is one result per clock. The stage count is set by the
// constant-reciprocal divisions (seconds per day, then days per 4-year cycle,
// then 60 for hours), which run in series: each takes a multiply stage, a
// remainder stage and a compare-and-correct stage. Each stage holds only
// while the stage after it is full and stalled, so bubbles close up and a
// stall drops or repeats nothing. No reset sweep: words are taken right
// after reset. Valid for the full 31-bit input range (1970..2038).
module epoch_seconds_to_calendar_top
  import es2cal_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  es2cal_in_if.sink     in_i,
  es2cal_out_if.source  out_o
);

  localparam int unsigned NumStages = 9;

  // ---- stage valid bits and advance chain --------------------------------
  logic [NumStages:1] vld_q;
  logic [NumStages:1] adv;
  logic [NumStages:1] vin;

  always_comb begin
    adv[NumStages] = !vld_q[NumStages] || out_o.ready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vin        = {vld_q[NumStages-1:1], in_i.valid};
  assign in_i.ready = adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NumStages; k++) begin
        if (adv[k]) vld_q[k] <= vin[k];
      end
    end
  end

  // ---- stage 1: seconds/128 times reciprocal of 675 ----------------------
  logic [30:0] s1_secs_q;
  logic [48:0] s1_prod_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_secs_q <= in_i.epoch_seconds;
      s1_prod_q <= 49'(in_i.epoch_seconds[30:7]) * 49'(DayRecip);
    end
  end

  // ---- stage 2: day estimate and remainder -------------------------------
  logic [14:0] s2_days_d;
  logic [31:0] s2_sub;
  logic [14:0] s2_days_q;
  logic [17:0] s2_rem_q;

  assign s2_days_d = s1_prod_q[48:34];
  assign s2_sub    = 32'(s1_secs_q) - 32'(s2_days_d) * 32'(SecPerDay);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_days_q <= s2_days_d;
      s2_rem_q  <= s2_sub[17:0];
    end
  end

  // ---- stage 3: correct the estimate (off by at most one) ----------------
  logic [14:0] s3_days_q;
  logic [16:0] s3_rem_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      if (s2_rem_q >= 18'(SecPerDay)) begin
        s3_days_q <= s2_days_q + 15'd1;
        s3_rem_q  <= 17'(s2_rem_q - 18'(SecPerDay));
      end else begin
        s3_days_q <= s2_days_q;
        s3_rem_q  <= s2_rem_q[16:0];
      end
    end
  end

  // ---- stage 4: 4-year cycle and minute products, weekday digit sum -----
  logic [14:0] s4_doff_d;
  logic [14:0] s4_wday_src;
  logic [5:0]  s4_wsum_d;
  logic [14:0] s4_doff_q;
  logic [29:0] s4_qprod_q;
  logic [31:0] s4_mprod_q;
  logic [16:0] s4_rem_q;
  logic [5:0]  s4_wsum_q;

  assign s4_doff_d   = s3_days_q + EpochDayOfs;
  assign s4_wday_src = s3_days_q + 15'(EpochWeekday);

  // 8 = 1 mod 7: summing octal digits keeps the value mod 7
  always_comb begin
    s4_wsum_d = '0;
    for (int k = 0; k < 5; k++) begin
      s4_wsum_d = s4_wsum_d + 6'(s4_wday_src[3*k +: 3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s4_doff_q  <= s4_doff_d;
      s4_qprod_q <= 30'(s4_doff_d) * 30'(QuadRecip);
      s4_mprod_q <= 32'(s3_rem_q[16:2]) * 32'(Recip15);
      s4_rem_q   <= s3_rem_q;
      s4_wsum_q  <= s4_wsum_d;
    end
  end

  // ---- stage 5: cycle and minute estimates with remainders ---------------
  logic [4:0]  s5_quad_d;
  logic [15:0] s5_r4_sub;
  logic [10:0] s5_mins_d;
  logic [16:0] s5_sec_sub;
  logic [4:0]  s5_quad_q;
  logic [11:0] s5_r4_q;
  logic [10:0] s5_mins_q;
  logic [6:0]  s5_sec_q;
  logic [3:0]  s5_wfold_q;

  assign s5_quad_d  = s4_qprod_q[29:25];
  assign s5_r4_sub  = 16'(s4_doff_q) - 16'(s5_quad_d) * 16'(QuadDays);
  assign s5_mins_d  = s4_mprod_q[30:20];
  assign s5_sec_sub = s4_rem_q - 17'(s5_mins_d) * 17'(Sixty);

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s5_quad_q  <= s5_quad_d;
      s5_r4_q    <= s5_r4_sub[11:0];
      s5_mins_q  <= s5_mins_d;
      s5_sec_q   <= s5_sec_sub[6:0];
      s5_wfold_q <= 4'(s4_wsum_q[5:3]) + 4'(s4_wsum_q[2:0]);
    end
  end

  // ---- stage 6: corrections, weekday final -------------------------------
  logic [4:0]  s6_quad_q;
  logic [10:0] s6_r4_q;
  logic [10:0] s6_mins_q;
  logic [5:0]  s6_sec_q;
  logic [2:0]  s6_wday_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      if (s5_r4_q >= 12'(QuadDays)) begin
        s6_quad_q <= s5_quad_q + 5'd1;
        s6_r4_q   <= 11'(s5_r4_q - 12'(QuadDays));
      end else begin
        s6_quad_q <= s5_quad_q;
        s6_r4_q   <= s5_r4_q[10:0];
      end
      if (s5_sec_q >= 7'(Sixty)) begin
        s6_mins_q <= s5_mins_q + 11'd1;
        s6_sec_q  <= 6'(s5_sec_q - 7'(Sixty));
      end else begin
        s6_mins_q <= s5_mins_q;
        s6_sec_q  <= s5_sec_q[5:0];
      end
      s6_wday_q <= (s5_wfold_q >= 4'(DaysPerWeek)) ?
                   3'(s5_wfold_q - 4'(DaysPerWeek)) : s5_wfold_q[2:0];
    end
  end

  // ---- stage 7: year within cycle, day of year, hour product -------------
  logic [1:0]  s7_yc_d;
  logic [10:0] s7_ystart_d;
  logic [10:0] s7_doy_sub;
  logic [8:0]  s7_doy_q;
  logic        s7_leap_q;
  logic [10:0] s7_year_q;
  logic [25:0] s7_hprod_q;
  logic [10:0] s7_mins_q;
  logic [5:0]  s7_sec_q;
  logic [2:0]  s7_wday_q;

  // only the first year of a cycle is leap; 2000 is leap, so the simple
  // rule matches the 4/100/400 rule over the whole input range
  always_comb begin
    if (s6_r4_q >= Year3Start) begin
      s7_yc_d     = 2'd3;
      s7_ystart_d = Year3Start;
    end else if (s6_r4_q >= Year2Start) begin
      s7_yc_d     = 2'd2;
      s7_ystart_d = Year2Start;
    end else if (s6_r4_q >= Year1Start) begin
      s7_yc_d     = 2'd1;
      s7_ystart_d = Year1Start;
    end else begin
      s7_yc_d     = 2'd0;
      s7_ystart_d = '0;
    end
  end

  assign s7_doy_sub = s6_r4_q - s7_ystart_d;

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      s7_doy_q   <= s7_doy_sub[8:0];
      s7_leap_q  <= (s7_yc_d == 2'd0);
      s7_year_q  <= BaseYear + {4'd0, s6_quad_q, 2'b00} + 11'(s7_yc_d);
      s7_hprod_q <= 26'(s6_mins_q[10:2]) * 26'(Recip15);
      s7_mins_q  <= s6_mins_q;
      s7_sec_q   <= s6_sec_q;
      s7_wday_q  <= s6_wday_q;
    end
  end

  // ---- stage 8: month index, hour estimate -------------------------------
  logic [3:0]  s8_mon_d;
  logic [4:0]  s8_hour_d;
  logic [10:0] s8_min_sub;
  logic [3:0]  s8_mon_q;
  logic [8:0]  s8_doy_q;
  logic        s8_leap_q;
  logic [10:0] s8_year_q;
  logic [4:0]  s8_hour_q;
  logic [6:0]  s8_min_q;
  logic [5:0]  s8_sec_q;
  logic [2:0]  s8_wday_q;

  // month starts are increasing, so the count of passed starts is the index
  always_comb begin
    s8_mon_d = '0;
    for (int k = 1; k < 12; k++) begin
      if (s7_doy_q >= month_start(4'(k), s7_leap_q)) s8_mon_d = s8_mon_d + 4'd1;
    end
  end

  assign s8_hour_d  = s7_hprod_q[24:20];
  assign s8_min_sub = s7_mins_q - 11'(s8_hour_d) * 11'(Sixty);

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      s8_mon_q  <= s8_mon_d;
      s8_doy_q  <= s7_doy_q;
      s8_leap_q <= s7_leap_q;
      s8_year_q <= s7_year_q;
      s8_hour_q <= s8_hour_d;
      s8_min_q  <= s8_min_sub[6:0];
      s8_sec_q  <= s7_sec_q;
      s8_wday_q <= s7_wday_q;
    end
  end

  // ---- stage 9: day of month, hour correction, output register -----------
  logic [8:0]  s9_day_sub;
  logic [4:0]  s9_day_q;
  logic [3:0]  s9_mon_q;
  logic [10:0] s9_year_q;
  logic [2:0]  s9_wday_q;
  logic [4:0]  s9_hour_q;
  logic [5:0]  s9_min_q;
  logic [5:0]  s9_sec_q;

  assign s9_day_sub = s8_doy_q - month_start(s8_mon_q, s8_leap_q) + 9'd1;

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      s9_day_q  <= s9_day_sub[4:0];
      s9_mon_q  <= s8_mon_q + 4'd1;
      s9_year_q <= s8_year_q;
      s9_wday_q <= s8_wday_q;
      s9_sec_q  <= s8_sec_q;
      if (s8_min_q >= 7'(Sixty)) begin
        s9_hour_q <= s8_hour_q + 5'd1;
        s9_min_q  <= 6'(s8_min_q - 7'(Sixty));
      end else begin
        s9_hour_q <= s8_hour_q;
        s9_min_q  <= s8_min_q[5:0];
      end
    end
  end

  // ---- output word -------------------------------------------------------
  assign out_o.valid            = vld_q[NumStages];
  assign out_o.day_of_month     = s9_day_q;
  assign out_o.month_number     = s9_mon_q;
  assign out_o.year_number      = s9_year_q;
  assign out_o.weekday          = s9_wday_q;
  assign out_o.hour_of_day      = s9_hour_q;
  assign out_o.minute_of_hour   = s9_min_q;
  assign out_o.second_of_minute = s9_sec_q;

endmodule

// File: hw/rtl/es2cal_checker.sv
// ---------------------------------------------------------------------------
// es2cal_checker
// Port-level checks on the calendar output channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_top_defines.svh"

module es2cal_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [4:0]  day_i,
  input logic [3:0]  month_i,
  input logic [10:0] year_i,
  input logic [2:0]  weekday_i,
  input logic [4:0]  hour_i,
  input logic [5:0]  minute_i,
  input logic [5:0]  second_i
);

  logic fields_ok;
  logic short_month;
  logic feb_ok;

  // calendar ranges of the output fields
  assign fields_ok = (month_i >= 4'd1) && (month_i <= 4'd12) && (day_i >= 5'd1) &&
                     (weekday_i <= 3'd6) && (hour_i <= 5'd23) &&
                     (minute_i <= 6'd59) && (second_i <= 6'd59) &&
                     (year_i >= 11'd1970) && (year_i <= 11'd2038);

  assign short_month = (month_i == 4'd4) || (month_i == 4'd6) ||
                       (month_i == 4'd9) || (month_i == 4'd11);

  assign feb_ok = (day_i <= 5'd28) || ((day_i == 5'd29) && (year_i[1:0] == 2'b00));

  // a stalled output word stays offered
  `ES2CAL_ASSERT(a_out_hold, (out_valid_i && !out_ready_i |=> out_valid_i))

  // every field of an offered word is inside its calendar range
  `ES2CAL_ASSERT_MSG(a_field_range, (out_valid_i |-> fields_ok), "es2cal: field out of range")

  // thirty-day months never show day 31
  `ES2CAL_ASSERT_MSG(a_short_month, (out_valid_i && short_month |-> day_i <= 5'd30), "es2cal: day 31")

  // February ends at 28, or 29 in a leap year
  `ES2CAL_ASSERT_MSG(a_february, (out_valid_i && month_i == 4'd2 |-> feb_ok), "es2cal: bad February")

endmodule

bind epoch_seconds_to_calendar_top es2cal_checker u_es2cal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .day_i       (out_o.day_of_month),
  .month_i     (out_o.month_number),
  .year_i      (out_o.year_number),
  .weekday_i   (out_o.weekday),
  .hour_i      (out_o.hour_of_day),
  .minute_i    (out_o.minute_of_hour),
  .second_i    (out_o.second_of_minute)
);
